/* design/hssr_pkg.sv */
// shared types, register indexes and status codes for the single-wire sensor reader
package hssr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;
  localparam int FRAME_BITS  = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_LOW     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_WAIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT       = 3'd4;

  localparam logic [22:0] MIN_INTERVAL_RESET = 23'd2000000;
  localparam logic [15:0] START_LOW_RESET    = 16'd1100;
  localparam logic [7:0]  RELEASE_WAIT_RESET = 8'd55;
  localparam logic [7:0]  HIGH_THRESH_RESET  = 8'd50;
  localparam logic [15:0] TIMEOUT_RESET      = 16'd15000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_CKSUM = 2'd2;

  typedef struct packed {
    logic [22:0] min_interval_ticks;
    logic [15:0] start_low_ticks;
    logic [7:0]  release_wait_ticks;
    logic [7:0]  high_threshold_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               drive_low;
    logic               done_res;
    logic [1:0]         status;
    logic               data_valid;
    logic signed [15:0] humidity_tenths;
    logic signed [15:0] temperature_tenths;
    logic               busy_res;
  } res_t;

endpackage

/* design/hssr_cfg_regs.sv */
// configuration registers with their reset values
module hssr_cfg_regs
  import hssr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ticks   <= MIN_INTERVAL_RESET;
      cfg.start_low_ticks      <= START_LOW_RESET;
      cfg.release_wait_ticks   <= RELEASE_WAIT_RESET;
      cfg.high_threshold_ticks <= HIGH_THRESH_RESET;
      cfg.timeout_ticks        <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_INTERVAL: cfg.min_interval_ticks   <= cfg_data[22:0];
        REG_START_LOW:    cfg.start_low_ticks      <= cfg_data[15:0];
        REG_RELEASE_WAIT: cfg.release_wait_ticks   <= cfg_data[7:0];
        REG_HIGH_THRESH:  cfg.high_threshold_ticks <= cfg_data[7:0];
        REG_TIMEOUT:      cfg.timeout_ticks        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* design/hssr_seq.sv */
// read sequencer: start pulse, response check, bit timing and frame check, one tick per step
module hssr_seq
  import hssr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic line_level,
  input  logic read_request,
  input  cfg_t cfg,
  output res_t res
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_START     = 3'd1;
  localparam logic [2:0] PH_RELEASE   = 3'd2;
  localparam logic [2:0] PH_RESP_LOW  = 3'd3;
  localparam logic [2:0] PH_RESP_HIGH = 3'd4;
  localparam logic [2:0] PH_PRE_LOW   = 3'd5;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd6;
  localparam logic [2:0] PH_BIT_LOW   = 3'd7;

  localparam logic [22:0] INTERVAL_MAX = '1;

  logic [2:0]            phase, phase_next;
  logic [15:0]           phase_counter, phase_counter_next;
  logic [22:0]           interval_counter, interval_counter_next;
  logic [5:0]            bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic                  valid_flag, valid_flag_next;
  logic [15:0]           held_humidity, held_humidity_next;
  logic [15:0]           held_temperature, held_temperature_next;

  logic        accepted;
  logic        done;
  logic [1:0]  stat;
  logic [15:0] pc_inc;
  logic        expect_high;
  logic        ended;
  logic        timed_out;
  logic [7:0]  sum8;

  assign pc_inc = phase_counter + 16'd1;
  assign sum8   = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
                + frame_shift[15:8];
  assign expect_high = (phase == PH_RESP_HIGH) || (phase == PH_BIT_HIGH);
  assign ended       = line_level != expect_high;
  assign timed_out   = !ended && (phase_counter >= cfg.timeout_ticks);

  always_comb begin
    phase_next            = phase;
    phase_counter_next    = phase_counter;
    bit_count_next        = bit_count;
    frame_shift_next      = frame_shift;
    valid_flag_next       = valid_flag;
    held_humidity_next    = held_humidity;
    held_temperature_next = held_temperature;
    accepted              = 1'b0;
    done                  = 1'b0;
    stat                  = ST_OK;

    unique case (phase)
      PH_IDLE: begin
        if (read_request) begin
          if (interval_counter >= cfg.min_interval_ticks) begin
            accepted           = 1'b1;
            valid_flag_next    = 1'b0;
            frame_shift_next   = '0;
            bit_count_next     = '0;
            phase_counter_next = '0;
            phase_next         = PH_START;
          end else begin
            // too early: report cached status without reading
            done = 1'b1;
            stat = valid_flag ? ST_OK : ST_FAIL;
          end
        end
      end
      PH_START: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= cfg.start_low_ticks) begin
          phase_next         = PH_RELEASE;
          phase_counter_next = '0;
        end
      end
      PH_RELEASE: begin
        phase_counter_next = pc_inc;
        if (pc_inc >= {8'd0, cfg.release_wait_ticks}) begin
          phase_next         = PH_RESP_LOW;
          phase_counter_next = '0;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_PRE_LOW, PH_BIT_HIGH, PH_BIT_LOW: begin
        if (!ended && !timed_out) begin
          phase_counter_next = pc_inc;
        end
        if (ended || timed_out) begin
          phase_counter_next = '0;
          unique case (phase)
            PH_RESP_LOW: begin
              if (timed_out) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                stat       = ST_FAIL;
              end else begin
                phase_next = PH_RESP_HIGH;
              end
            end
            PH_RESP_HIGH: begin
              if (timed_out) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                stat       = ST_FAIL;
              end else begin
                phase_next = PH_PRE_LOW;
              end
            end
            PH_PRE_LOW: begin
              phase_next = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
              if (timed_out) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                stat       = ST_FAIL;
              end else begin
                frame_shift_next = {frame_shift[FRAME_BITS-2:0],
                                    phase_counter > {8'd0, cfg.high_threshold_ticks}};
                bit_count_next   = bit_count + 6'd1;
                phase_next       = PH_BIT_LOW;
              end
            end
            default: begin
              // low phase after a bit; a timeout here simply ends the phase
              if (bit_count >= 6'(FRAME_BITS)) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                if (sum8 != frame_shift[7:0]) begin
                  stat = ST_CKSUM;
                end else begin
                  stat                  = ST_OK;
                  held_humidity_next    = frame_shift[39:24];
                  held_temperature_next = frame_shift[23:8];
                  valid_flag_next       = 1'b1;
                end
              end else begin
                phase_next = PH_BIT_HIGH;
              end
            end
          endcase
        end
      end
    endcase

    if (accepted) begin
      interval_counter_next = '0;
    end else if (interval_counter != INTERVAL_MAX) begin
      interval_counter_next = interval_counter + 23'd1;
    end else begin
      interval_counter_next = interval_counter;
    end
  end

  always_comb begin
    res.drive_low          = phase_next == PH_START;
    res.done_res           = done;
    res.status             = done ? stat : ST_OK;
    res.data_valid         = valid_flag_next;
    res.humidity_tenths    = valid_flag_next ? held_humidity_next : 16'sd0;
    res.temperature_tenths = valid_flag_next ? held_temperature_next : 16'sd0;
    res.busy_res           = phase_next != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      phase_counter    <= '0;
      interval_counter <= INTERVAL_MAX;
      bit_count        <= '0;
      frame_shift      <= '0;
      valid_flag       <= 1'b0;
      held_humidity    <= '0;
      held_temperature <= '0;
    end else if (step) begin
      phase            <= phase_next;
      phase_counter    <= phase_counter_next;
      interval_counter <= interval_counter_next;
      bit_count        <= bit_count_next;
      frame_shift      <= frame_shift_next;
      valid_flag       <= valid_flag_next;
      held_humidity    <= held_humidity_next;
      held_temperature <= held_temperature_next;
    end
  end

endmodule

/* design/hssr_out_reg.sv */
// result register holding one transaction until the receiver takes it
module hssr_out_reg
  import hssr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output res_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* design/humidity_sensor_single_wire_reader.sv */
// Single-wire humidity/temperature sensor reader.
// Each input transaction is one microsecond tick: the sampled data line level and a
// read request. Each input transaction yields exactly one output transaction carrying
// the line drive, a done pulse with status, and the held readings with their valid flag.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), to be used only while idle
// (the block does not enforce this): 0 min interval, 1 start low ticks, 2 release wait,
// 3 high threshold, 4 timeout. An accepted tick's result is registered and appears on the
// outputs in the next cycle. Throughput is one tick per cycle while in_ready is high; the
// sequencer state updates in a single pass. in_ready is high while the result register is
// empty or being taken, so when the receiver stalls, at most one result waits and input
// stops until it is taken. Reset clears the sequencer to idle, drops held readings and
// valid flag, sets the interval counter to its maximum so the first request may start at
// once, and loads the configuration defaults. Nothing is pending after reset.
// The data line is driven low while drive_low is high; busy_res shows a running read.
module humidity_sensor_single_wire_reader
  import hssr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     line_level,
  input  logic                     read_request,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     drive_low,
  output logic                     done_res,
  output logic [1:0]               status,
  output logic                     data_valid,
  output logic signed [15:0]       humidity_tenths,
  output logic signed [15:0]       temperature_tenths,
  output logic                     busy_res,
  input  logic                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t cfg;
  res_t res_next;
  res_t res_q;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  hssr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hssr_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .line_level   (line_level),
    .read_request (read_request),
    .cfg          (cfg),
    .res          (res_next)
  );

  hssr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign drive_low          = res_q.drive_low;
  assign done_res           = res_q.done_res;
  assign status             = res_q.status;
  assign data_valid         = res_q.data_valid;
  assign humidity_tenths    = res_q.humidity_tenths;
  assign temperature_tenths = res_q.temperature_tenths;
  assign busy_res           = res_q.busy_res;

endmodule

/* design/hssr_checker.sv */
// port-level checks for the sensor reader, bound to the top level
module hssr_checker
  import hssr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   drive_low,
  input logic                   done_res,
  input logic [1:0]             status,
  input logic                   data_valid,
  input logic signed [15:0]     humidity_tenths,
  input logic signed [15:0]     temperature_tenths,
  input logic                   busy_res
);

  // a stalled result holds its status, done flag, humidity and busy flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(done_res)
      && $stable(humidity_tenths) && $stable(busy_res))
    else $error("stalled result changed");

  // each accepted tick produces a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == ST_OK)
    else $error("status set without done");

  a_readings_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> humidity_tenths == 16'sd0 && temperature_tenths == 16'sd0)
    else $error("readings shown without valid data");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_low |-> busy_res && !done_res)
    else $error("line driven outside a running read");

endmodule

bind humidity_sensor_single_wire_reader hssr_checker u_hssr_checker (.*);

/* tb/sv/tb_humidity_sensor_single_wire_reader.sv */
// testbench for the single-wire sensor reader: tick-by-tick prediction of every result transaction
`timescale 1ns / 1ps

module tb_humidity_sensor_single_wire_reader;
  import hssr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_RELEASE,
    SEQ_RESP_LOW,
    SEQ_RESP_HIGH,
    SEQ_PRE_LOW,
    SEQ_BIT_HIGH,
    SEQ_BIT_LOW
  } seq_phase_t;

  typedef enum int {
    RD_GOOD,
    RD_BAD_SUM,
    RD_RESP_LOW_TO,
    RD_RESP_HIGH_TO,
    RD_BIT_HIGH_TO,
    RD_BIT_LOW_TO,
    RD_NOISE
  } read_kind_t;

  class reading_checker;
    cfg_t        regs;
    seq_phase_t  phase;
    logic [15:0] phase_cnt;
    logic [22:0] since_read;
    int unsigned bits_seen;
    logic [39:0] frame;
    logic        valid;
    logic [15:0] hum;
    logic [15:0] temp;
    res_t        expected_readings[$];
    int unsigned errors;

    function new();
      regs.min_interval_ticks   = MIN_INTERVAL_RESET;
      regs.start_low_ticks      = START_LOW_RESET;
      regs.release_wait_ticks   = RELEASE_WAIT_RESET;
      regs.high_threshold_ticks = HIGH_THRESH_RESET;
      regs.timeout_ticks        = TIMEOUT_RESET;
      phase      = SEQ_IDLE;
      phase_cnt  = '0;
      since_read = '1;
      bits_seen  = 0;
      frame      = '0;
      valid      = 1'b0;
      hum        = '0;
      temp       = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      unique case (idx)
        REG_MIN_INTERVAL: regs.min_interval_ticks   = val;
        REG_START_LOW:    regs.start_low_ticks      = val[15:0];
        REG_RELEASE_WAIT: regs.release_wait_ticks   = val[7:0];
        REG_HIGH_THRESH:  regs.high_threshold_ticks = val[7:0];
        REG_TIMEOUT:      regs.timeout_ticks        = val[15:0];
        default: ;
      endcase
    endfunction

    function bit running();
      return phase != SEQ_IDLE;
    endfunction

    function bit in_prelude();
      return phase == SEQ_START || phase == SEQ_RELEASE;
    endfunction

    function bit may_start();
      return since_read >= regs.min_interval_ticks;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // advance one tick and queue the result it produces
    function void note_tick(logic lvl, logic req);
      res_t        r;
      logic        done;
      logic [1:0]  st;
      logic        started;
      logic        want_lvl;
      logic        ended;
      logic        timed_out;
      logic [15:0] dur;
      logic [7:0]  sum;
      done    = 1'b0;
      st      = ST_OK;
      started = 1'b0;
      unique case (phase)
        SEQ_IDLE: begin
          if (req) begin
            if (may_start()) begin
              started   = 1'b1;
              valid     = 1'b0;
              frame     = '0;
              bits_seen = 0;
              phase_cnt = '0;
              phase     = SEQ_START;
            end else begin
              done = 1'b1;
              st   = valid ? ST_OK : ST_FAIL;
            end
          end
        end
        SEQ_START: begin
          phase_cnt = phase_cnt + 16'd1;
          if (phase_cnt >= regs.start_low_ticks) begin
            phase     = SEQ_RELEASE;
            phase_cnt = '0;
          end
        end
        SEQ_RELEASE: begin
          phase_cnt = phase_cnt + 16'd1;
          if (phase_cnt >= {8'd0, regs.release_wait_ticks}) begin
            phase     = SEQ_RESP_LOW;
            phase_cnt = '0;
          end
        end
        default: begin
          want_lvl  = (phase == SEQ_RESP_HIGH || phase == SEQ_BIT_HIGH);
          ended     = (lvl != want_lvl);
          timed_out = 1'b0;
          dur       = phase_cnt;
          if (!ended) begin
            if (phase_cnt >= regs.timeout_ticks) timed_out = 1'b1;
            else phase_cnt = phase_cnt + 16'd1;
          end
          if (ended || timed_out) begin
            phase_cnt = '0;
            unique case (phase)
              SEQ_RESP_LOW, SEQ_RESP_HIGH: begin
                if (timed_out) begin
                  phase = SEQ_IDLE;
                  done  = 1'b1;
                  st    = ST_FAIL;
                end else begin
                  phase = (phase == SEQ_RESP_LOW) ? SEQ_RESP_HIGH : SEQ_PRE_LOW;
                end
              end
              SEQ_PRE_LOW: phase = SEQ_BIT_HIGH;
              SEQ_BIT_HIGH: begin
                if (timed_out) begin
                  phase = SEQ_IDLE;
                  done  = 1'b1;
                  st    = ST_FAIL;
                end else begin
                  frame     = {frame[38:0], dur > {8'd0, regs.high_threshold_ticks}};
                  bits_seen = bits_seen + 1;
                  phase     = SEQ_BIT_LOW;
                end
              end
              default: begin
                // a low phase that times out simply ends
                if (bits_seen >= FRAME_BITS) begin
                  phase = SEQ_IDLE;
                  done  = 1'b1;
                  sum   = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                  if (sum != frame[7:0]) begin
                    st = ST_CKSUM;
                  end else begin
                    hum   = frame[39:24];
                    temp  = frame[23:8];
                    valid = 1'b1;
                    st    = ST_OK;
                  end
                end else begin
                  phase = SEQ_BIT_HIGH;
                end
              end
            endcase
          end
        end
      endcase
      if (started) since_read = '0;
      else if (since_read != '1) since_read = since_read + 23'd1;

      r.drive_low          = (phase == SEQ_START);
      r.done_res           = done;
      r.status             = done ? st : ST_OK;
      r.data_valid         = valid;
      r.humidity_tenths    = valid ? hum : '0;
      r.temperature_tenths = valid ? temp : '0;
      r.busy_res           = (phase != SEQ_IDLE);
      expected_readings.push_back(r);
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, $signed(want), $signed(seen));
        errors++;
      end
    endfunction

    function void check_result(res_t seen);
      res_t want;
      if (expected_readings.size() == 0) begin
        $error("result transaction with no tick waiting for it");
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      check_field("drive_low", 16'(want.drive_low), 16'(seen.drive_low));
      check_field("done_res", 16'(want.done_res), 16'(seen.done_res));
      check_field("status", 16'(want.status), 16'(seen.status));
      check_field("data_valid", 16'(want.data_valid), 16'(seen.data_valid));
      check_field("humidity_tenths", want.humidity_tenths, seen.humidity_tenths);
      check_field("temperature_tenths", want.temperature_tenths, seen.temperature_tenths);
      check_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic line_level = 1'b0;
  logic read_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic drive_low;
  logic done_res;
  logic [1:0] status;
  logic data_valid;
  logic signed [15:0] humidity_tenths;
  logic signed [15:0] temperature_tenths;
  logic busy_res;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  res_t seen_result;
  reading_checker readings;
  int idle_pct = 0;
  int stall_pct = 0;
  int unsigned cycle_count = 0;

  assign seen_result = {drive_low, done_res, status, data_valid, humidity_tenths,
                        temperature_tenths, busy_res};

  humidity_sensor_single_wire_reader u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .line_level(line_level),
    .read_request(read_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive_low(drive_low),
    .done_res(done_res),
    .status(status),
    .data_valid(data_valid),
    .humidity_tenths(humidity_tenths),
    .temperature_tenths(temperature_tenths),
    .busy_res(busy_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** humidity_sensor_single_wire_reader: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) readings.check_result(seen_result);
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // one tick transaction; returns at the edge that accepted it, or later when idle_pct inserts an idle gap
  task automatic send_tick(input logic lvl, input logic req);
    line_level   <= lvl;
    read_request <= req;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    readings.note_tick(lvl, req);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // requests on top of a running read must be ignored
  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_tick(lvl, readings.running() && $urandom_range(15, 0) == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (readings.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    readings.set_reg(idx, val);
  endtask

  task automatic load_settings(input logic [22:0] min_int, input logic [15:0] start_low,
                               input logic [7:0] rel_wait, input logic [7:0] thr,
                               input logic [15:0] tmo);
    wait_drained();
    put_reg(REG_MIN_INTERVAL, min_int);
    put_reg(REG_START_LOW, 23'(start_low));
    put_reg(REG_RELEASE_WAIT, 23'(rel_wait));
    put_reg(REG_HIGH_THRESH, 23'(thr));
    put_reg(REG_TIMEOUT, 23'(tmo));
    cfg_we <= 1'b0;
  endtask

  function automatic int short_len(int tmo);
    return $urandom_range((tmo < 2) ? tmo : 2, 0);
  endfunction

  // ticks spent in the bit high phase, capped at the timeout
  function automatic int pulse_len(logic one, int thr, int tmo);
    int d;
    d = one ? thr + 1 + $urandom_range(2, 0) : $urandom_range(thr, 0);
    return (d > tmo) ? tmo : d;
  endfunction

  // one read sequence; each run's first tick closes the phase before it
  task automatic do_read(input read_kind_t kind, input logic [31:0] payload);
    logic [39:0] word;
    logic [7:0]  flip;
    int tmo;
    int thr;
    int cut;
    tmo  = int'(readings.regs.timeout_ticks);
    thr  = int'(readings.regs.high_threshold_ticks);
    word = {payload, payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0]};
    flip = 8'($urandom_range(255, 1));
    if (kind == RD_BAD_SUM) word[7:0] = word[7:0] ^ flip;
    cut = $urandom_range(39, 0);

    repeat ($urandom_range(3, 0)) send_tick(1'($urandom), 1'b0);
    if (!readings.may_start()) send_tick(1'($urandom), 1'b1);
    while (!readings.may_start()) send_tick(1'($urandom), 1'b0);
    send_tick(1'($urandom), 1'b1);
    while (readings.in_prelude()) send_tick(1'($urandom), $urandom_range(7, 0) == 0);

    if (kind == RD_NOISE) begin
      repeat ($urandom_range(60, 20)) send_tick(1'($urandom), $urandom_range(9, 0) == 0);
    end else if (kind == RD_RESP_LOW_TO) begin
      send_run(1'b0, tmo + 1);
    end else begin
      send_run(1'b0, short_len(tmo));
      if (kind == RD_RESP_HIGH_TO) begin
        send_run(1'b1, tmo + 2);
      end else begin
        send_run(1'b1, 1 + short_len(tmo));
        send_run(1'b0, 1 + short_len(tmo));
        for (int i = 39; i >= 0; i--) begin
          if (kind == RD_BIT_HIGH_TO && i == cut) break;
          send_run(1'b1, 1 + pulse_len(word[i], thr, tmo));
          send_run(1'b0, (kind == RD_BIT_LOW_TO && i == cut) ? tmo + 2 : 1 + short_len(tmo));
        end
        // closing edge of the last low phase, or a high pulse that never ends
        send_run(1'b1, (kind == RD_BIT_HIGH_TO) ? tmo + 2 : 1);
      end
    end
    while (readings.running()) send_tick(1'($urandom), 1'b0);
  endtask

  task automatic run_reads(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(9, 0);
      if (pick <= 3 || readings.regs.timeout_ticks > 64) do_read(RD_GOOD, $urandom);
      else do_read(read_kind_t'(pick - 3), $urandom);
    end
  endtask

  initial begin
    readings = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // longest interval, release wait and timeout; the interval counter starts saturated
    load_settings(23'h7FFFFF, 16'd1, 8'hFF, 8'd1, 16'hFFFF);
    do_read(RD_GOOD, 32'h8000_7FFF);
    send_tick(1'b0, 1'b1);

    // zero timeout and zero start: one-tick start, instant timeout, refusals
    load_settings(23'd30, 16'd0, 8'd0, 8'd0, 16'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    do_read(RD_GOOD, 32'h0000_0000);
    send_tick(1'b0, 1'b1);

    load_settings(23'd0, 16'd2, 8'd1, 8'd1, 16'd6);
    do_read(RD_GOOD, 32'hFFFF_FFFF);

    idle_pct = 79;
    load_settings(23'd20, 16'd1, 8'd3, 8'd2, 16'd8);
    run_reads(1);

    idle_pct  = 0;
    stall_pct = 79;
    load_settings(23'd0, 16'd3, 8'd2, 8'd0, 16'd3);
    run_reads(1);
    wait_drained();
    run_reads(1);

    idle_pct  = 8;
    stall_pct = 8;
    load_settings(23'd12, 16'd4, 8'd0, 8'd0, 16'd1);
    run_reads(2);

    idle_pct  = 0;
    stall_pct = 0;
    load_settings(23'd3, 16'd1, 8'd1, 8'd2, 16'd200);
    run_reads(1);

    wait_drained();
    if (readings.errors == 0 && readings.pending() == 0) begin
      $display("** humidity_sensor_single_wire_reader: PASSED **");
    end else begin
      $display("** humidity_sensor_single_wire_reader: FAILED **");
    end
    $finish;
  end

endmodule

/* humidity_sensor_single_wire_reader.f */
design/hssr_pkg.sv
design/hssr_cfg_regs.sv
design/hssr_seq.sv
design/hssr_out_reg.sv
design/humidity_sensor_single_wire_reader.sv
design/hssr_checker.sv
tb/sv/tb_humidity_sensor_single_wire_reader.sv
